[hdl/spsa_pkg.sv]
// Shared types, constants and bit-search helpers for the strided port slot allocator.
`default_nettype none

package spsa_pkg;

  // Bitmap geometry; WORD_BITS must be a power of two.
  localparam int SLOT_COUNT = 256;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  // Slot index plus one spare bit so that "highest + 1" never wraps.
  localparam int SLOT_W     = WIDX_W + BIT_W + 1;

  localparam int PORT_W     = 16;
  localparam int STEP_W     = 16;
  localparam int LIMIT_W    = 17;
  localparam int PROD_W     = SLOT_W + STEP_W;
  localparam int DIV_CNT_W  = $clog2(PORT_W);

  localparam logic [LIMIT_W-1:0] PORT_SPAN = LIMIT_W'(65536);

  // Request codes.
  localparam logic [1:0] OP_ALLOC_ANY   = 2'd0;
  localparam logic [1:0] OP_ALLOC_GIVEN = 2'd1;
  localparam logic [1:0] OP_RELEASE     = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_TAKEN   = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_STEP  = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [PORT_W-1:0] port_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PORT_W-1:0] granted_port;
  } out_item_t;

  typedef struct packed {
    logic              done;
    logic [PORT_W-1:0] quot;
    logic [STEP_W-1:0] rem;
  } div_res_t;

  // Position of the highest set bit (zero if none).
  function automatic logic [BIT_W-1:0] msb_index(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (w[b]) idx = BIT_W'(b);
    end
    return idx;
  endfunction

  // Position of the lowest set bit (zero if none).
  function automatic logic [BIT_W-1:0] lsb_index(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (w[b]) idx = BIT_W'(b);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[hdl/spsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module spsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/spsa_div.sv]
// Iterative restoring divider, one quotient bit per cycle, for the stride check.
`default_nettype none

module spsa_div import spsa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PORT_W-1:0] dividend,
  input  wire logic [STEP_W-1:0] divisor,
  output div_res_t               res
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [STEP_W-1:0]    acc;
  logic [PORT_W-1:0]    quo;
  logic [STEP_W-1:0]    dvs;

  logic [STEP_W:0] trial;
  logic [STEP_W:0] diff;
  logic            fits;

  assign trial = {acc, quo[PORT_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        acc <= fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
        quo <= {quo[PORT_W-2:0], fits};
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(PORT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quot = quo;
  assign res.rem  = acc;

endmodule

`default_nettype wire

[hdl/strided_port_slot_allocator.sv]
// Top level: strided port allocator over an occupancy bitmap held in RAM.
//
//  channel  direction  handshake        payload
//  in       input      in_valid/stall   in_item_t  {opcode, port_number}
//  out      output     out_valid/stall  out_item_t {status, granted_port}
//  cfg      input      cfg_valid/ready  cfg_index, cfg_data (base, step, limit)
//
// One request is in flight at a time. Allocate-given and release wait on
// the 16-step divider that checks the stride. Allocate-any time is set by
// the word-by-word scans of the bitmap RAM (one flag per cycle downward, then
// a scan and an evaluate state per word upward). Reset is synchronous and
// clears the per-word nonempty flags at once; a word whose flag is clear reads
// as all free, so no clearing pass runs. A finished result waits in the output
// register while out_stall holds.
`default_nettype none

module strided_port_slot_allocator import spsa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [LIMIT_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HI_SCAN,
    S_HI_EVAL,
    S_LO_SCAN,
    S_LO_EVAL,
    S_MUL,
    S_CHK,
    S_RANGE,
    S_DIV_WAIT,
    S_MOD_RD,
    S_MOD_WR,
    S_RESP
  } state_t;

  state_t state;

  // Configuration registers.
  logic [PORT_W-1:0]  base_port;
  logic [STEP_W-1:0]  port_step;
  logic [LIMIT_W-1:0] limit_port;

  // Request and working registers.
  logic [1:0]            op;
  logic [PORT_W-1:0]     port;
  logic [WORD_COUNT-1:0] nonempty;
  logic [WIDX_W-1:0]     widx;
  logic [BIT_W-1:0]      bsel;
  logic [SLOT_W-1:0]     cand;
  logic                  hi_mode;
  logic [PROD_W-1:0]     prod;
  logic [1:0]            res_status;
  logic [PORT_W-1:0]     res_port;

  // Derived values.
  logic [STEP_W-1:0]    eff_step;
  logic [LIMIT_W-1:0]   eff_limit;
  logic                 in_range;
  logic [PORT_W-1:0]    offset;
  logic [PROD_W:0]      slot_sum;
  logic                 usable;
  logic                 quot_in_map;
  logic                 out_free;
  logic                 is_given;

  // Bitmap RAM and its read-modify-write path.
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] word_eff;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] set_word;
  logic [WORD_BITS-1:0] clr_word;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_we;

  logic     div_start;
  div_res_t div_res;

  assign cfg_ready = !rst;
  assign in_stall  = rst || (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign is_given  = (op == OP_ALLOC_GIVEN);

  // A step of zero acts as one; limits past the port space clamp to it.
  assign eff_step  = (port_step == '0) ? STEP_W'(1) : port_step;
  assign eff_limit = (limit_port > PORT_SPAN) ? PORT_SPAN : limit_port;

  assign in_range    = (port >= base_port) && ({1'b0, port} < eff_limit);
  assign offset      = port - base_port;
  assign slot_sum    = (PROD_W + 1)'(base_port) + {1'b0, prod};
  assign usable      = (cand < SLOT_W'(SLOT_COUNT)) &&
                       (slot_sum < (PROD_W + 1)'(eff_limit));
  assign quot_in_map = {1'b0, div_res.quot} < (PORT_W + 1)'(SLOT_COUNT);

  // RAM content is only meaningful while the word's nonempty flag is set.
  assign word_eff  = nonempty[widx] ? ram_rdata : '0;
  assign bit_mask  = WORD_BITS'(1) << bsel;
  assign set_word  = word_eff | bit_mask;
  assign clr_word  = word_eff & ~bit_mask;
  assign ram_wdata = (op == OP_RELEASE) ? clr_word : set_word;
  assign ram_we    = (state == S_MOD_WR) && !(is_given && word_eff[bsel]);

  assign div_start = (state == S_RANGE) && in_range;

  spsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx),
    .wdata (ram_wdata),
    .raddr (widx),
    .rdata (ram_rdata)
  );

  spsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (offset),
    .divisor  (eff_step),
    .res      (div_res)
  );

  // Configuration writes; the user must issue them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_port  <= '0;
      port_step  <= STEP_W'(1);
      limit_port <= LIMIT_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE:  base_port  <= cfg_data[PORT_W-1:0];
        CFG_STEP:  port_step  <= cfg_data[STEP_W-1:0];
        CFG_LIMIT: limit_port <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Request sequencer. The RAM reads widx every cycle, so data for the word
  // addressed in one state shows up in the state after it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      nonempty <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op   <= in_data.opcode;
            port <= in_data.port_number;
            unique case (in_data.opcode)
              OP_ALLOC_ANY: begin
                widx    <= WIDX_W'(WORD_COUNT - 1);
                hi_mode <= 1'b1;
                state   <= S_HI_SCAN;
              end
              OP_ALLOC_GIVEN, OP_RELEASE: state <= S_RANGE;
              default: begin
                res_status <= ST_INVALID;
                res_port   <= '0;
                state      <= S_RESP;
              end
            endcase
          end
        end

        // Walk the flags down to the highest nonempty word.
        S_HI_SCAN: begin
          if (nonempty[widx]) begin
            state <= S_HI_EVAL;
          end else if (widx == '0) begin
            hi_mode <= 1'b0;
            state   <= S_LO_SCAN;
          end else begin
            widx <= widx - WIDX_W'(1);
          end
        end

        // Try one above the highest occupied slot.
        S_HI_EVAL: begin
          cand  <= SLOT_W'({widx, msb_index(word_eff)}) + SLOT_W'(1);
          state <= S_MUL;
        end

        // Walk up for the lowest free slot; an empty word is free at bit 0.
        S_LO_SCAN: begin
          if (!nonempty[widx]) begin
            cand  <= SLOT_W'({widx, BIT_W'(0)});
            state <= S_MUL;
          end else begin
            state <= S_LO_EVAL;
          end
        end

        S_LO_EVAL: begin
          if (~word_eff != '0) begin
            cand  <= SLOT_W'({widx, lsb_index(~word_eff)});
            state <= S_MUL;
          end else if (widx == WIDX_W'(WORD_COUNT - 1)) begin
            res_status <= ST_NONE;
            res_port   <= '0;
            state      <= S_RESP;
          end else begin
            widx  <= widx + WIDX_W'(1);
            state <= S_LO_SCAN;
          end
        end

        S_MUL: begin
          prod  <= PROD_W'(cand) * PROD_W'(eff_step);
          state <= S_CHK;
        end

        // Candidate port in range: claim it. Otherwise fall back to the
        // lowest free slot once, then give up.
        S_CHK: begin
          if (usable) begin
            widx     <= cand[BIT_W +: WIDX_W];
            bsel     <= cand[BIT_W-1:0];
            res_port <= slot_sum[PORT_W-1:0];
            state    <= S_MOD_RD;
          end else if (hi_mode) begin
            hi_mode <= 1'b0;
            widx    <= '0;
            state   <= S_LO_SCAN;
          end else begin
            res_status <= ST_NONE;
            res_port   <= '0;
            state      <= S_RESP;
          end
        end

        S_RANGE: begin
          if (!in_range) begin
            res_status <= is_given ? ST_INVALID : ST_OK;
            res_port   <= '0;
            state      <= S_RESP;
          end else begin
            state <= S_DIV_WAIT;
          end
        end

        // Off-stride ports are invalid, slots past the bitmap taken (a release answers OK to either).
        S_DIV_WAIT: begin
          if (div_res.done) begin
            if (div_res.rem != '0) begin
              res_status <= is_given ? ST_INVALID : ST_OK;
              res_port   <= '0;
              state      <= S_RESP;
            end else if (!quot_in_map) begin
              res_status <= is_given ? ST_TAKEN : ST_OK;
              res_port   <= '0;
              state      <= S_RESP;
            end else begin
              widx     <= div_res.quot[BIT_W +: WIDX_W];
              bsel     <= div_res.quot[BIT_W-1:0];
              res_port <= is_given ? port : '0;
              state    <= S_MOD_RD;
            end
          end
        end

        S_MOD_RD: state <= S_MOD_WR;

        // Write back the modified word and refresh its nonempty flag, unless the given slot is already taken.
        S_MOD_WR: begin
          if (op == OP_RELEASE) begin
            nonempty[widx] <= (clr_word != '0);
            res_status     <= ST_OK;
            res_port       <= '0;
          end else if (is_given && word_eff[bsel]) begin
            res_status <= ST_TAKEN;
            res_port   <= '0;
          end else begin
            nonempty[widx] <= 1'b1;
            res_status     <= ST_OK;
          end
          state <= S_RESP;
        end

        S_RESP: begin
          if (out_free) state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load when free, drop on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      out_valid             <= 1'b1;
      out_data.status       <= res_status;
      out_data.granted_port <= res_port;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hdl/spsa_checker.sv]
// Port-level checker for the strided port slot allocator, bound to the top level.
`default_nettype none

module spsa_checker import spsa_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire out_item_t          out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // One request at a time: a transfer in closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  // Failures never carry a port number.
  a_fail_no_port: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.granted_port == '0)
    else $error("failed request reported a granted port");

endmodule

bind strided_port_slot_allocator spsa_checker u_spsa_checker (.*);

`default_nettype wire

[tb/tb_strided_port_slot_allocator.sv]
// Self-checking testbench for the strided port slot allocator: directed and random requests.
`default_nettype none

module tb_strided_port_slot_allocator;
  import spsa_pkg::*;

  // The package names only the three defined requests; the spare code answers invalid.
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  // Percentage of requests (input) or cycles (output) in which a side idles while gaps are enabled.
  localparam int IDLE_PCT = 19;
  // Longest allocate-any scan plus margin; let the block settle this long before
  // touching registers and before the final verdict.
  localparam int SETTLE_CYCLES = 3 * WORD_COUNT + 20;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_BASE;
  logic [LIMIT_W-1:0] cfg_data  = '0;

  // Shadow copy of the allocator: slot occupancy and the three registers.
  logic [SLOT_COUNT-1:0] occupied;
  int                    cur_base;
  int                    cur_step;
  int                    cur_limit;

  out_item_t expected_grants[$];
  int        errors    = 0;
  bit        gaps_on   = 1'b1;
  int        hold_req  = 0;
  int        hold_left = 0;

  strided_port_slot_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Allocator prediction
  // ---------------------------------------------------------------------------

  // A step of zero behaves as one.
  function automatic int eff_step();
    return (cur_step == 0) ? 1 : cur_step;
  endfunction

  // No port exceeds 65535, so larger limits saturate at the port span.
  function automatic int eff_limit();
    return (cur_limit > 65536) ? 65536 : cur_limit;
  endfunction

  function automatic bit slot_usable(int k);
    return (k < SLOT_COUNT) && (cur_base + k * eff_step() < eff_limit());
  endfunction

  // Map a port to its slot index; fail when out of range or off the stride.
  function automatic bit port_slot(int port, output int k);
    int off;
    k = 0;
    if (port < cur_base || port >= eff_limit()) return 1'b0;
    off = port - cur_base;
    if (off % eff_step() != 0) return 1'b0;
    k = off / eff_step();
    return 1'b1;
  endfunction

  // Number of slots from zero up to the last usable one.
  function automatic int usable_span();
    int n;
    n = 0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (slot_usable(k)) n = k + 1;
    end
    return n;
  endfunction

  // Apply one request to the shadow bitmap and return the answer it earns.
  function automatic out_item_t grant_request(in_item_t req);
    out_item_t res;
    int        k;
    int        top;
    int        first_free;
    bit        found;
    res.status       = ST_OK;
    res.granted_port = '0;
    k          = 0;
    top        = -1;
    first_free = -1;
    found      = 1'b0;
    case (req.opcode)
      OP_ALLOC_ANY: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (occupied[i]) top = i;
        end
        // Try one past the highest occupied slot, then fall back to the lowest free one.
        if (top >= 0 && slot_usable(top + 1)) begin
          k     = top + 1;
          found = 1'b1;
        end else begin
          for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!occupied[i]) first_free = i;
          end
          k     = first_free;
          found = (first_free >= 0) && slot_usable(first_free);
        end
        if (found) begin
          occupied[k]      = 1'b1;
          res.granted_port = PORT_W'(cur_base + k * eff_step());
        end else begin
          res.status = ST_NONE;
        end
      end
      OP_ALLOC_GIVEN: begin
        if (!port_slot(req.port_number, k)) begin
          res.status = ST_INVALID;
        end else if (k >= SLOT_COUNT || occupied[k]) begin
          // Slots past the bitmap never come free.
          res.status = ST_TAKEN;
        end else begin
          occupied[k]      = 1'b1;
          res.granted_port = req.port_number;
        end
      end
      OP_RELEASE: begin
        // Drop invalid ports and slots past the bitmap silently.
        if (port_slot(req.port_number, k) && k < SLOT_COUNT) occupied[k] = 1'b0;
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver back-pressure
  // ---------------------------------------------------------------------------

  task automatic report(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    // Values read here are the ones in place at this edge.
    if (!rst && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        report("unexpected result transfer, status", out_data.status, 0);
      end else begin
        want = expected_grants.pop_front();
        if (out_data.status != want.status)
          report("status", out_data.status, want.status);
        if (out_data.granted_port != want.granted_port)
          report("granted_port", out_data.granted_port, want.granted_port);
      end
    end
    // Pick up a requested hold-off and count it down here.
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until the transfer happens, then predict.
  // Leave valid high afterwards; the next call replaces the request or lowers valid, the drain lowers it.
  task automatic send_request(logic [1:0] op, logic [PORT_W-1:0] port);
    if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'{op, port};
    do @(posedge clk); while (in_stall);
    expected_grants.push_back(grant_request(in_data));
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_grants.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= LIMIT_W'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASE: cur_base  = value & 32'hFFFF;
      CFG_STEP: cur_step  = value & 32'hFFFF;
      default:  cur_limit = value & 32'h1FFFF;
    endcase
  endtask

  // Reprogram all three registers once the block has gone quiet.
  task automatic set_config(int base, int step, int limit);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_BASE, base);
    write_reg(CFG_STEP, step);
    write_reg(CFG_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: on-stride ports near the usable range so the
  // bitmap fills, empties and hits the bitmap edge; some noise on top.
  task automatic random_requests(int count);
    int                pick;
    int                k;
    logic [1:0]        op;
    logic [PORT_W-1:0] port;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) k = $urandom_range(SLOT_COUNT + 63);
      else k = $urandom_range(usable_span() + 3);
      port = PORT_W'(cur_base + k * eff_step());
      if (pick < 40) begin
        op   = OP_ALLOC_ANY;
        port = PORT_W'($urandom);
      end else if (pick < 65) begin
        op = OP_ALLOC_GIVEN;
      end else if (pick < 88) begin
        op = OP_RELEASE;
      end else if (pick < 97) begin
        op   = $urandom_range(1) ? OP_ALLOC_GIVEN : OP_RELEASE;
        port = PORT_W'($urandom);
      end else begin
        op   = OP_UNKNOWN;
        port = PORT_W'($urandom);
      end
      send_request(op, port);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: ports 0..255, step one.
  task automatic test_reset_config_edges();
    send_request(OP_ALLOC_ANY, 16'h0000);     // empty bitmap: lowest slot
    send_request(OP_ALLOC_ANY, 16'hFFFF);     // one past the highest
    send_request(OP_ALLOC_GIVEN, 16'd255);    // top usable slot
    send_request(OP_ALLOC_ANY, 16'h0000);     // above the top is unusable: lowest free
    send_request(OP_ALLOC_GIVEN, 16'd255);    // taken
    send_request(OP_ALLOC_GIVEN, 16'd256);    // at the limit: invalid
    send_request(OP_ALLOC_GIVEN, 16'hFFFF);   // far out of range
    send_request(OP_RELEASE, 16'd255);
    send_request(OP_RELEASE, 16'd255);        // free a free slot
    send_request(OP_RELEASE, 16'hFFFF);       // invalid port: ignored
    send_request(OP_UNKNOWN, 16'hFFFF);
    send_request(OP_ALLOC_GIVEN, 16'd0);      // taken
    send_request(OP_RELEASE, 16'd0);
    send_request(OP_RELEASE, 16'd1);
  endtask

  // Range, stride and bitmap-edge checks under a few hand-picked settings.
  task automatic test_stride_and_bounds();
    set_config(0, 1, 65536);
    send_request(OP_ALLOC_GIVEN, 16'd300);    // past the bitmap: taken
    send_request(OP_RELEASE, 16'd300);        // past the bitmap: ignored
    send_request(OP_ALLOC_GIVEN, 16'hFFFF);
    set_config(10, 3, 40);
    send_request(OP_ALLOC_GIVEN, 16'd9);      // below base
    send_request(OP_ALLOC_GIVEN, 16'd11);     // off stride
    send_request(OP_ALLOC_GIVEN, 16'd13);
    send_request(OP_ALLOC_GIVEN, 16'd40);     // at the limit
    send_request(OP_ALLOC_GIVEN, 16'd37);     // last usable slot
    send_request(OP_RELEASE, 16'd13);
    set_config(100, 1, 50);                   // limit below base: nothing usable
    send_request(OP_ALLOC_ANY, 16'h0000);
    send_request(OP_ALLOC_GIVEN, 16'd100);
  endtask

  // Walk through register settings, extremes included; occupancy carries over.
  task automatic test_config_sweep();
    int sweep_base[10]  = '{0, 0,     1000, 65535, 0,     5,   40000,   300, 100, 0};
    int sweep_step[10]  = '{1, 1,     3,    65535, 65535, 0,   7,       2,   1,   1};
    int sweep_limit[10] = '{256, 65536, 1800, 65536, 65536, 200, 'h1FFFF, 301, 1,   100};
    for (int c = 0; c < 10; c++) begin
      set_config(sweep_base[c], sweep_step[c], sweep_limit[c]);
      random_requests(95);
    end
  endtask

  // Hold off the receiver for a long stretch while requests keep coming, so the
  // block backs up and stalls its input; pause until all results are in, then send random requests.
  task automatic test_output_backpressure();
    set_config(0, 1, 256);
    hold_req = 300;
    for (int n = 0; n < 12; n++) send_request(OP_ALLOC_ANY, PORT_W'($urandom));
    wait_drained();
    random_requests(40);
  endtask

  // Back-to-back transfers on both sides.
  task automatic test_no_gaps();
    gaps_on = 1'b0;
    random_requests(200);
    gaps_on = 1'b1;
  endtask

  initial begin
    occupied  = '0;
    cur_base  = 0;
    cur_step  = 1;
    cur_limit = 256;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_config_edges();
    test_stride_and_bounds();
    test_config_sweep();
    test_output_backpressure();
    test_no_gaps();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_grants.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
